// ----- design/blpw_pkg.sv -----
// Package with the shared constants and control types of the line pixel writer.
`default_nettype none
package blpw_pkg;

  localparam int IN_COORD_W     = 6;
  localparam int VALUE_W        = 32;
  localparam int ADDR_W         = 10;
  localparam int CFG_W          = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int IN_TDATA_W     = 4 * IN_COORD_W + VALUE_W;
  localparam int OUT_TDATA_W    = 48;

  localparam int DEF_COORD_BITS = 6;
  localparam int DEF_MAX_SIDE   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     RESET_SIDE       = 6'd32;

  typedef struct packed {
    logic load;
    logic orient;
    logic order;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- design/blpw_ctrl.sv -----
// Controller state machine that sequences line setup and the pixel walk.
`default_nettype none
module blpw_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  wire              m_tready,
  output blpw_pkg::dp_cmd_t    cmd,
  input  blpw_pkg::dp_status_t status
);
  import blpw_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ORIENT = 2'd1;
  localparam logic [1:0] ST_ORDER  = 2'd2;
  localparam logic [1:0] ST_WALK   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       can_emit;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign can_emit = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_ORIENT;
        end
      end
      ST_ORIENT: begin
        cmd.orient = 1'b1;
        state_next = ST_ORDER;
      end
      ST_ORDER: begin
        cmd.order  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (can_emit) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/blpw_datapath.sv -----
// Datapath with the size registers, line setup, Bresenham stepper and output register.
`default_nettype none
module blpw_datapath #(
  parameter int COORD_BITS = blpw_pkg::DEF_COORD_BITS,
  parameter int MAX_SIDE   = blpw_pkg::DEF_MAX_SIDE
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  blpw_pkg::dp_cmd_t                    cmd,
  output blpw_pkg::dp_status_t                 status,
  input  wire [blpw_pkg::IN_TDATA_W-1:0]       s_tdata,
  input  wire                                  cfg_we,
  input  wire [blpw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [blpw_pkg::CFG_W-1:0]            cfg_data,
  output logic [blpw_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);
  import blpw_pkg::*;

  localparam int CW      = COORD_BITS;
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int LIMIT_W = 2 * SIDE_W;
  localparam int AW      = 2 * SIDE_W + CW;
  localparam int PAD_W   = OUT_TDATA_W - ADDR_W - VALUE_W;

  logic [CFG_W-1:0]       image_width;
  logic [CFG_W-1:0]       image_height;
  logic [SIDE_W-1:0]      w_eff;
  logic [SIDE_W-1:0]      h_eff;

  logic signed [CW-1:0]   x0, y0, x1, y1;
  logic signed [CW-1:0]   a0, b0, a1, b1;
  logic [VALUE_W-1:0]     held_value;
  logic                   steep_flag;
  logic signed [CW-1:0]   major_pos;
  logic signed [CW-1:0]   major_end;
  logic signed [CW-1:0]   minor_pos;
  logic [CW:0]            major_delta;
  logic [CW:0]            minor_delta;
  logic                   minor_dir;
  logic signed [CW+1:0]   error_term;
  logic [LIMIT_W-1:0]     limit;

  logic signed [CW:0]     dx, dy;
  logic [CW:0]            adx, ady;
  logic                   steep_now;
  logic                   swap;
  logic signed [CW-1:0]   oa0, ob0, oa1, ob1;
  logic signed [CW:0]     dmaj, dmin;

  logic signed [CW+1:0]   err_sub;
  logic signed [CW-1:0]   row, col;
  logic signed [AW-1:0]   addr;
  logic                   in_image;
  logic                   last;

  assign w_eff = (image_width > CFG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                  : image_width[SIDE_W-1:0];
  assign h_eff = (image_height > CFG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                   : image_height[SIDE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_SIDE;
      image_height <= RESET_SIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Orientation: a steep line walks along rows.
  assign dx        = $signed({x1[CW-1], x1}) - $signed({x0[CW-1], x0});
  assign dy        = $signed({y1[CW-1], y1}) - $signed({y0[CW-1], y0});
  assign adx       = dx[CW] ? (CW+1)'(-dx) : dx;
  assign ady       = dy[CW] ? (CW+1)'(-dy) : dy;
  assign steep_now = ady > adx;

  // Ordering: the major coordinate rises along the walk.
  assign swap = a0 > a1;
  assign oa0  = swap ? a1 : a0;
  assign ob0  = swap ? b1 : b0;
  assign oa1  = swap ? a0 : a1;
  assign ob1  = swap ? b0 : b1;
  assign dmaj = $signed({oa1[CW-1], oa1}) - $signed({oa0[CW-1], oa0});
  assign dmin = $signed({ob1[CW-1], ob1}) - $signed({ob0[CW-1], ob0});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0         <= s_tdata[CW-1:0];
      y0         <= s_tdata[IN_COORD_W +: CW];
      x1         <= s_tdata[2*IN_COORD_W +: CW];
      y1         <= s_tdata[3*IN_COORD_W +: CW];
      held_value <= s_tdata[4*IN_COORD_W +: VALUE_W];
    end
    if (cmd.orient) begin
      steep_flag <= steep_now;
      a0         <= steep_now ? y0 : x0;
      b0         <= steep_now ? x0 : y0;
      a1         <= steep_now ? y1 : x1;
      b1         <= steep_now ? x1 : y1;
    end
    if (cmd.order) begin
      major_pos   <= oa0;
      major_end   <= oa1;
      minor_pos   <= ob0;
      major_delta <= dmaj;
      minor_delta <= dmin[CW] ? (CW+1)'(-dmin) : dmin;
      minor_dir   <= !(ob0 < ob1);
      error_term  <= $signed({1'b0, dmaj}) >>> 1;
      limit       <= LIMIT_W'(w_eff) * LIMIT_W'(h_eff);
    end
    if (cmd.step) begin
      error_term <= err_sub;
      if (err_sub < 0) begin
        minor_pos  <= minor_dir ? minor_pos - CW'(1) : minor_pos + CW'(1);
        error_term <= err_sub + $signed({1'b0, major_delta});
      end
      if (!last) begin
        major_pos <= major_pos + CW'(1);
      end
      m_tdata <= {PAD_W'(0), held_value, in_image ? addr[ADDR_W-1:0] : ADDR_W'(0)};
      m_tuser <= in_image;
      m_tlast <= last;
    end
  end

  assign err_sub  = error_term - $signed({1'b0, minor_delta});
  assign row      = steep_flag ? major_pos : minor_pos;
  assign col      = steep_flag ? minor_pos : major_pos;
  assign addr     = AW'(row) * $signed(AW'(w_eff)) + AW'(col);
  assign in_image = !addr[AW-1] && (addr[AW-2:0] < (AW-1)'(limit));
  assign last     = major_pos >= major_end;

  assign status.last = last;

endmodule
`default_nettype wire

// ----- design/bresenham_line_pixel_writer.sv -----
// A line item is loaded, then oriented and ordered, before the stepper emits its first pixel item.
// Throughput: one pixel item per cycle from the stepper while the output is not stalled; a line of n steps
// (1 to 64) occupies the single stepper, which takes no new line item until it is done.
// A new line item is taken once the last pixel sits in the output register.
// Synchronous active-high reset idles the block and sets both sizes to 32.
`default_nettype none
module bresenham_line_pixel_writer #(
  parameter int COORD_BITS = blpw_pkg::DEF_COORD_BITS,
  parameter int MAX_SIDE   = blpw_pkg::DEF_MAX_SIDE
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // start_x, start_y, end_x, end_y, pixel_value
  input  wire [blpw_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // pixel_address, write_data, zero fill
  output logic [blpw_pkg::OUT_TDATA_W-1:0] m_tdata,
  // write_enable
  output logic                             m_tuser,
  output logic                             m_tlast,
  input  wire                              cfg_we,
  input  wire [blpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [blpw_pkg::CFG_W-1:0]        cfg_data
);
  import blpw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  blpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  blpw_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_SIDE   (MAX_SIDE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
